### hdl/chct_pkg.sv
// Shared constants for the chained hash color table: field widths, operation
// and configuration register codes, and default sizes for the top level.
// No dependencies; chct_hash and the top level import this package.
package chct_pkg;

  localparam int KEY_W      = 32;
  localparam int COLOR_W    = 32;
  localparam int OP_W       = 2;
  localparam int CHARS_W    = 3;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Width that holds any bucket count or entry limit in the parameter range.
  localparam int NEED_W = 17;

  localparam int DEF_MAX_ENTRIES   = 1024;
  localparam int DEF_MAX_BUCKETS   = 1024;
  localparam int DEF_MIN_BUCKETS   = 256;
  localparam int DEF_MAX_KEY_CHARS = 4;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LIMIT = 2'd1;

  localparam logic [CHARS_W-1:0] RST_KEY_CHARS   = 3'd1;
  localparam logic [LIMIT_W-1:0] RST_ENTRY_LIMIT = 11'd1024;

endpackage

### hdl/chained_hash_color_table.sv
// Chained hash color table top level: command FSM, head and entry memories.
// A command steps through the hash, head read and chain walk states; clear, a dropped
// insert and an unknown operation finish in the hash state. The next start is taken
// in the result cycle. The chain walk is one entry memory read per cycle.
// After reset the head memory is swept, one bucket a cycle (1024 by default),
// with busy high; results cannot be stalled. Depends on chct_pkg, chct_ram, chct_hash.
module chained_hash_color_table #(
  parameter int MAX_ENTRIES   = chct_pkg::DEF_MAX_ENTRIES,
  parameter int MAX_BUCKETS   = chct_pkg::DEF_MAX_BUCKETS,
  parameter int MIN_BUCKETS   = chct_pkg::DEF_MIN_BUCKETS,
  parameter int MAX_KEY_CHARS = chct_pkg::DEF_MAX_KEY_CHARS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [chct_pkg::OP_W-1:0]         in_operation,
  input  logic [chct_pkg::KEY_W-1:0]        in_key,
  input  logic [chct_pkg::COLOR_W-1:0]      in_color,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chct_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                              out_valid,
  output logic [chct_pkg::COLOR_W-1:0]      out_found_color,
  output logic                              out_hit,
  output logic                              out_full_res
);
  import chct_pkg::*;

  localparam int ENT_W     = $clog2(MAX_ENTRIES);
  localparam int USED_W    = $clog2(MAX_ENTRIES + 1);
  localparam int BKT_W     = $clog2(MAX_BUCKETS + 1) - 1;
  localparam int BKT_DEPTH = 1 << BKT_W;

  // Entry word: {key, color, link, link valid, bucket filed under}.
  localparam int LV_POS    = BKT_W;
  localparam int LINK_LSB  = BKT_W + 1;
  localparam int COLOR_LSB = LINK_LSB + ENT_W;
  localparam int KEY_LSB   = COLOR_LSB + COLOR_W;
  localparam int ENT_WORD  = KEY_LSB + KEY_W;

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_HASH = 3'd2;
  localparam logic [2:0] ST_HEAD = 3'd3;
  localparam logic [2:0] ST_WALK = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [BKT_W-1:0]   init_addr_r, init_addr_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic               first_r, first_nxt;
  logic [CHARS_W-1:0] key_chars_r, key_chars_nxt;
  logic [LIMIT_W-1:0] entry_limit_r, entry_limit_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [COLOR_W-1:0] color_r;
  logic [BKT_W-1:0]   bucket_r;
  logic [ENT_W-1:0]   head_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_hit_r;
  logic               out_full_r;

  logic               take;
  logic               res_load;
  logic [COLOR_W-1:0] res_color;
  logic               res_hit;
  logic               res_full;

  logic [NEED_W-1:0]  lim;
  logic [BKT_W-1:0]   hash_bucket;
  logic [KEY_W-1:0]   cmp_mask;

  logic               head_we;
  logic [BKT_W-1:0]   head_waddr;
  logic [ENT_W-1:0]   head_wdata;
  logic [ENT_W-1:0]   head_rdata;

  logic               ent_we;
  logic [ENT_W-1:0]   ent_raddr;
  logic [ENT_WORD-1:0] ent_wdata;
  logic [ENT_WORD-1:0] ent_rdata;

  logic [KEY_W-1:0]   ent_key;
  logic [COLOR_W-1:0] ent_color;
  logic [ENT_W-1:0]   ent_link;
  logic               ent_lvalid;
  logic [BKT_W-1:0]   ent_bucket;
  logic               head_ok;
  logic               cur_ok;
  logic               key_match;
  logic               full;

  assign busy      = (state_r != ST_IDLE);
  assign take      = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    lim = NEED_W'(entry_limit_r);
    if (lim == '0) begin
      lim = NEED_W'(1);
    end
    if (lim > NEED_W'(MAX_ENTRIES)) begin
      lim = NEED_W'(MAX_ENTRIES);
    end
  end

  chct_hash #(
    .MAX_BUCKETS  (MAX_BUCKETS),
    .MIN_BUCKETS  (MIN_BUCKETS),
    .MAX_KEY_CHARS(MAX_KEY_CHARS)
  ) u_hash (
    .key      (key_r),
    .key_chars(key_chars_r),
    .limit    (lim),
    .bucket   (hash_bucket),
    .cmp_mask (cmp_mask)
  );

  assign ent_key    = ent_rdata[KEY_LSB +: KEY_W];
  assign ent_color  = ent_rdata[COLOR_LSB +: COLOR_W];
  assign ent_link   = ent_rdata[LINK_LSB +: ENT_W];
  assign ent_lvalid = ent_rdata[LV_POS];
  assign ent_bucket = ent_rdata[BKT_W-1:0];

  // A head is live only if it names an entry written since the last clear and
  // that entry was filed under this bucket; a later insert into the bucket
  // would have replaced any stale head, so no per-bucket valid bit is needed.
  assign head_ok   = (USED_W'(head_r) < used_r) && (ent_bucket == bucket_r);
  assign cur_ok    = first_r ? head_ok : 1'b1;
  assign key_match = ((ent_key ^ key_r) & cmp_mask) == '0;
  assign full      = NEED_W'(used_r) >= lim;

  assign head_we    = (state_r == ST_INIT) || (state_r == ST_WALK && op_r == OP_INSERT);
  assign head_waddr = (state_r == ST_INIT) ? init_addr_r : bucket_r;
  assign head_wdata = (state_r == ST_INIT) ? '0 : used_r[ENT_W-1:0];

  assign ent_we    = (state_r == ST_WALK) && (op_r == OP_INSERT);
  assign ent_raddr = (state_r == ST_HEAD) ? head_rdata : ent_link;
  assign ent_wdata = {key_r, color_r, head_r, head_ok, bucket_r};

  chct_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BKT_DEPTH)
  ) u_head_ram (
    .clk  (clk),
    .we   (head_we),
    .waddr(head_waddr),
    .wdata(head_wdata),
    .raddr(hash_bucket),
    .rdata(head_rdata)
  );

  chct_ram #(
    .WIDTH(ENT_WORD),
    .DEPTH(MAX_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ent_we),
    .waddr(used_r[ENT_W-1:0]),
    .wdata(ent_wdata),
    .raddr(ent_raddr),
    .rdata(ent_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    init_addr_nxt   = init_addr_r;
    used_nxt        = used_r;
    first_nxt       = first_r;
    key_chars_nxt   = key_chars_r;
    entry_limit_nxt = entry_limit_r;
    res_load        = 1'b0;
    res_color       = '0;
    res_hit         = 1'b0;
    res_full        = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_KEY_CHARS:   key_chars_nxt = cfg_wdata[CHARS_W-1:0];
        CFG_ENTRY_LIMIT: entry_limit_nxt = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_INIT: begin
        init_addr_nxt = init_addr_r + BKT_W'(1);
        if (init_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        case (op_r)
          OP_CLEAR: begin
            used_nxt  = '0;
            res_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
          OP_INSERT: begin
            if (full) begin
              res_full  = 1'b1;
              res_load  = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_HEAD;
            end
          end
          OP_LOOKUP: state_nxt = ST_HEAD;
          default: begin
            res_load  = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_HEAD: begin
        first_nxt = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (op_r == OP_INSERT) begin
          used_nxt  = used_r + USED_W'(1);
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cur_ok && key_match) begin
          res_color = ent_color;
          res_hit   = 1'b1;
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (cur_ok && ent_lvalid) begin
          // Next link is already being read through ent_raddr.
          first_nxt = 1'b0;
        end else begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = res_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      init_addr_r   <= '0;
      used_r        <= '0;
      first_r       <= 1'b0;
      key_chars_r   <= RST_KEY_CHARS;
      entry_limit_r <= RST_ENTRY_LIMIT;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      init_addr_r   <= init_addr_nxt;
      used_r        <= used_nxt;
      first_r       <= first_nxt;
      key_chars_r   <= key_chars_nxt;
      entry_limit_r <= entry_limit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op_r    <= in_operation;
      key_r   <= in_key;
      color_r <= in_color;
    end
    if (state_r == ST_HASH) begin
      bucket_r <= hash_bucket;
    end
    if (state_r == ST_HEAD) begin
      head_r <= head_rdata;
    end
    if (res_load) begin
      out_color_r <= res_color;
      out_hit_r   <= res_hit;
      out_full_r  <= res_full;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found_color = out_color_r;
  assign out_hit         = out_hit_r;
  assign out_full_res    = out_full_r;

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe high in two consecutive cycles");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_color == '0)
    else $error("nonzero color without a hit");

  a_hit_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_full_res))
    else $error("hit and full flagged together");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !head_we && !ent_we)
    else $error("memory written while idle");

endmodule

### hdl/chct_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing; every table memory is an instance of this module.
module chct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/chct_hash.sv
// Bucket hash unit: hash*33 plus each key byte, kept to the bucket index width,
// masked to the current bucket count; also gives the key compare byte mask.
// Depends on chct_pkg.
module chct_hash #(
  parameter int MAX_BUCKETS   = chct_pkg::DEF_MAX_BUCKETS,
  parameter int MIN_BUCKETS   = chct_pkg::DEF_MIN_BUCKETS,
  parameter int MAX_KEY_CHARS = chct_pkg::DEF_MAX_KEY_CHARS
) (
  input  logic [chct_pkg::KEY_W-1:0]              key,
  input  logic [chct_pkg::CHARS_W-1:0]            key_chars,
  input  logic [chct_pkg::NEED_W-1:0]             limit,
  output logic [$clog2(MAX_BUCKETS+1)-2:0]        bucket,
  output logic [chct_pkg::KEY_W-1:0]              cmp_mask
);
  import chct_pkg::*;

  localparam int BKT_W    = $clog2(MAX_BUCKETS + 1) - 1;
  localparam int CHAR_CAP = (MAX_KEY_CHARS < 4) ? MAX_KEY_CHARS : 4;
  localparam logic [NEED_W-1:0] CAP_MASK  = NEED_W'((1 << BKT_W) - 1);
  localparam logic [NEED_W-1:0] MIN_NEED  = NEED_W'(MIN_BUCKETS);

  logic [CHARS_W-1:0] nchars;
  logic [BKT_W-1:0]   hash;
  logic [NEED_W-1:0]  need;
  logic [NEED_W-1:0]  smear;
  logic [NEED_W-1:0]  mask;

  always_comb begin
    nchars = key_chars;
    if (nchars == '0) begin
      nchars = CHARS_W'(1);
    end
    if (nchars > CHARS_W'(CHAR_CAP)) begin
      nchars = CHARS_W'(CHAR_CAP);
    end
  end

  // Only the low BKT_W bits of the 32-bit hash ever reach the bucket index,
  // so the running hash is kept at that width.
  always_comb begin
    hash = '0;
    for (int i = 0; i < 4; i++) begin
      if (CHARS_W'(i) < nchars) begin
        hash = hash + (hash << 5) + BKT_W'(key[8*i +: 8]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cmp_mask[8*i +: 8] = (CHARS_W'(i) < nchars) ? 8'hff : 8'h00;
    end
  end

  // Smallest power of two at or above the need, minus one, capped at the
  // bucket memory size.
  always_comb begin
    need  = (limit > MIN_NEED) ? limit : MIN_NEED;
    smear = need - NEED_W'(1);
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    mask  = (smear > CAP_MASK) ? CAP_MASK : smear;
  end

  assign bucket = hash & mask[BKT_W-1:0];

endmodule
